// ===== design/mf2d_pkg.sv =====
// shared constants and types of the 2d median filter
package mf2d_pkg;

    localparam int MAX_KERNEL_DEF = 9;
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    localparam int RES_MAX = 5;
    localparam int JW      = 3;
    localparam int KW      = 4;
    localparam int DIM_W   = 12;

    localparam logic [KW-1:0]    KERNEL_RST = 4'd3;
    localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        REG_KERNEL = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic               first;
        logic [JW-1:0]      jmax;
        logic [RES_MAX-1:0] mask;
        logic               fd;
    } job_ctl_t;

endpackage

// ===== design/mf2d_if.sv =====
// pixel input and median output stream interfaces
interface mf2d_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] pixel;
    modport source (output valid, output op, output pixel, input ready);
    modport sink (input valid, input op, input pixel, output ready);
endinterface

interface mf2d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] median_pixel;
    logic       last_of_run;
    logic       frame_done;
    modport source (output valid, output median_pixel, output last_of_run,
                    output frame_done, input ready);
    modport sink (input valid, input median_pixel, input last_of_run,
                  input frame_done, output ready);
endinterface

// ===== design/mf2d_fifo.sv =====
// small job queue between front and back
module mf2d_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata,
    output logic              empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] buf_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [NW-1:0]     count_reg;

    assign full  = (count_reg == NW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = buf_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ===== design/mf2d_front.sv =====
// input side: position counters, line store and column gathering
module mf2d_front #(
    parameter int MAX_KERNEL = mf2d_pkg::MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = mf2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mf2d_pkg::MAX_HEIGHT_DEF,
    parameter int WW         = $clog2(MAX_WIDTH) + 1,
    parameter int HW         = $clog2(MAX_HEIGHT) + 1,
    parameter int DATA_W     = $bits(mf2d_pkg::job_ctl_t) + 8 * MAX_KERNEL
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mf2d_in_if.sink              pix_in,
    input  logic [2:0]           radius,
    input  logic [WW-1:0]        width,
    input  logic [HW-1:0]        height,
    input  logic                 restart,
    output logic                 push,
    output logic [DATA_W-1:0]    push_data,
    input  logic                 full
);
    localparam int LS_ROWS = (MAX_KERNEL == 1) ? 1 : MAX_KERNEL - 1;
    localparam int SW      = (LS_ROWS > 1) ? $clog2(LS_ROWS) : 1;
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int RW      = $clog2(MAX_HEIGHT + MAX_KERNEL) + 1;

    logic [LS_ROWS-1:0][7:0] line_mem [MAX_WIDTH];
    logic [LS_ROWS-1:0][7:0] rdata_reg;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [SW-1:0] rp_reg;

    logic                    s1_valid_reg;
    mf2d_pkg::job_ctl_t      s1_ctl_reg;
    logic [MAX_KERNEL-1:0]   s1_sel_reg;
    logic [SW-1:0]           s1_slot_reg [MAX_KERNEL];
    logic [7:0]              s1_pixel_reg;

    logic                  accept;
    logic                  rs;
    logic [CW-1:0]         cc;
    logic [RW-1:0]         rc;
    logic [SW-1:0]         rpc;
    logic [RW-1:0]         lim;
    logic                  drain;
    logic                  ign;
    logic                  last_col;
    logic [MAX_KERNEL-1:0] sel_c;
    logic [SW-1:0]         slot_c [MAX_KERNEL];
    mf2d_pkg::job_ctl_t    ctl_c;
    logic [CW-1:0]         col_next;
    logic [RW-1:0]         row_next;
    logic [SW-1:0]         rp_next;
    logic [8*MAX_KERNEL-1:0] col_vec;

    assign pix_in.ready = !s1_valid_reg || !full;
    assign accept       = pix_in.valid && pix_in.ready;
    assign push         = s1_valid_reg && !full;

    always_comb
    begin
        logic [RW:0] a;
        logic [RW:0] v;
        logic [RW:0] d;
        logic [RW:0] dm;
        logic [RW:0] two_r;
        lim   = RW'(height) - 1'b1 + RW'(radius);
        rs    = (WW'(col_reg) >= width) || (row_reg > lim);
        cc    = rs ? '0 : col_reg;
        rc    = rs ? '0 : row_reg;
        rpc   = rs ? '0 : rp_reg;
        drain = (rc >= RW'(height));
        ign   = (pix_in.op == mf2d_pkg::OP_DRAIN) && !drain;
        last_col = (WW'(cc) == width - 1'b1);
        two_r = (RW + 1)'(radius) << 1;
        for (int i = 0; i < MAX_KERNEL; i++)
        begin
            a = (RW + 1)'(rc) + (RW + 1)'(i);
            v = (a < two_r) ? '0 : a - two_r;
            if (v > (RW + 1)'(height) - 1'b1)
            begin
                v = (RW + 1)'(height) - 1'b1;
            end
            d  = (RW + 1)'(rc) - v;
            dm = (d >= (RW + 1)'(LS_ROWS)) ? d - (RW + 1)'(LS_ROWS) : d;
            sel_c[i]  = (d == '0) && !drain;
            slot_c[i] = ((RW + 1)'(rpc) >= dm) ? SW'((RW + 1)'(rpc) - dm)
                                              : SW'((RW + 1)'(rpc) + (RW + 1)'(LS_ROWS) - dm);
        end
        ctl_c.first = (cc == '0);
        ctl_c.jmax  = last_col ? radius : '0;
        ctl_c.fd    = last_col && (rc == lim);
        for (int j = 0; j < mf2d_pkg::RES_MAX; j++)
        begin
            ctl_c.mask[j] = (rc >= RW'(radius)) && (WW'(cc) + WW'(j) >= WW'(radius))
                            && (3'(j) <= ctl_c.jmax);
        end
        col_next = cc + 1'b1;
        row_next = rc;
        rp_next  = rpc;
        if (last_col)
        begin
            col_next = '0;
            row_next = rc + 1'b1;
            rp_next  = (rpc == SW'(LS_ROWS - 1)) ? '0 : rpc + 1'b1;
            if (rc + 1'b1 > lim)
            begin
                row_next = '0;
                rp_next  = '0;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_KERNEL; i++)
        begin
            col_vec[i*8 +: 8] = s1_sel_reg[i] ? s1_pixel_reg : rdata_reg[s1_slot_reg[i]];
        end
    end

    assign push_data = {s1_ctl_reg, col_vec};

    always_ff @(posedge clk)
    begin
        if (accept && !ign)
        begin
            rdata_reg <= line_mem[cc];
            if (!drain)
            begin
                line_mem[cc][rpc] <= pix_in.pixel;
            end
            s1_ctl_reg   <= ctl_c;
            s1_sel_reg   <= sel_c;
            s1_slot_reg  <= slot_c;
            s1_pixel_reg <= pix_in.pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            rp_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
                rp_reg  <= '0;
            end
            else if (accept)
            begin
                if (ign)
                begin
                    col_reg <= cc;
                    row_reg <= rc;
                    rp_reg  <= rpc;
                end
                else
                begin
                    col_reg <= col_next;
                    row_reg <= row_next;
                    rp_reg  <= rp_next;
                end
            end
            if (accept && !ign)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (push)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== design/mf2d_back.sv =====
// output side: window registers and bit-serial median search
module mf2d_back #(
    parameter int MAX_KERNEL = mf2d_pkg::MAX_KERNEL_DEF,
    parameter int DATA_W     = $bits(mf2d_pkg::job_ctl_t) + 8 * MAX_KERNEL
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [3:0]        kernel,
    input  logic [DATA_W-1:0] job_data,
    input  logic              empty,
    output logic              pop,
    mf2d_out_if.source        pix_out
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_NEXT = 5'b00010,
        S_CNT  = 5'b00100,
        S_SUM  = 5'b01000,
        S_EMIT = 5'b10000
    } bstate_t;

    bstate_t state_reg;
    bstate_t state_next;

    logic [7:0]         win_reg [MAX_KERNEL][MAX_KERNEL];
    logic [3:0]         cnt_reg [MAX_KERNEL];
    logic [3:0]         cnt_c   [MAX_KERNEL];
    mf2d_pkg::job_ctl_t ctl_reg;
    mf2d_pkg::job_ctl_t head_ctl;
    logic [mf2d_pkg::JW-1:0] j_reg;
    logic [2:0]         b_reg;
    logic [7:0]         prefix_reg;
    logic [6:0]         t_reg;
    logic [6:0]         total;
    logic [6:0]         target;
    logic [7:0]         himask;
    logic               out_valid_reg;
    logic [7:0]         med_reg;
    logic               last_reg;
    logic               fd_reg;
    logic               out_free;
    logic               advance;
    logic               edge_shift;
    logic               emit;
    logic               last_c;

    assign head_ctl = job_data[DATA_W-1 -: $bits(mf2d_pkg::job_ctl_t)];
    assign target   = 7'(({3'b0, kernel} * {3'b0, kernel}) >> 1);
    assign himask   = 8'(8'hFE << b_reg);
    assign out_free = !out_valid_reg || pix_out.ready;
    assign pop      = (state_reg == S_IDLE) && !empty;
    assign emit     = (state_reg == S_EMIT) && out_free;
    assign advance  = ((state_reg == S_NEXT) && !ctl_reg.mask[j_reg]) || emit;
    assign edge_shift = advance && (j_reg != ctl_reg.jmax);
    assign last_c   = (mf2d_pkg::RES_MAX'((ctl_reg.mask >> j_reg) >> 1) == '0);

    assign pix_out.valid        = out_valid_reg;
    assign pix_out.median_pixel = med_reg;
    assign pix_out.last_of_run  = last_reg;
    assign pix_out.frame_done   = fd_reg;

    always_comb
    begin
        for (int c = 0; c < MAX_KERNEL; c++)
        begin
            cnt_c[c] = '0;
            for (int r = 0; r < MAX_KERNEL; r++)
            begin
                if ((4'(r) < kernel) && (((win_reg[c][r] ^ prefix_reg) & himask) == '0)
                    && !win_reg[c][r][b_reg])
                begin
                    cnt_c[c] = cnt_c[c] + 1'b1;
                end
            end
            if (4'(c) >= kernel)
            begin
                cnt_c[c] = '0;
            end
        end
        total = '0;
        for (int c = 0; c < MAX_KERNEL; c++)
        begin
            total = total + 7'(cnt_reg[c]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (ctl_reg.mask[j_reg])
                begin
                    state_next = S_CNT;
                end
                else if (j_reg == ctl_reg.jmax)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CNT:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = (b_reg == '0) ? S_EMIT : S_CNT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (j_reg == ctl_reg.jmax) ? S_IDLE : S_NEXT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ctl_reg <= head_ctl;
            for (int r = 0; r < MAX_KERNEL; r++)
            begin
                win_reg[0][r] <= job_data[r*8 +: 8];
            end
            for (int c = 1; c < MAX_KERNEL; c++)
            begin
                for (int r = 0; r < MAX_KERNEL; r++)
                begin
                    win_reg[c][r] <= head_ctl.first ? job_data[r*8 +: 8] : win_reg[c-1][r];
                end
            end
        end
        else if (edge_shift)
        begin
            for (int c = 1; c < MAX_KERNEL; c++)
            begin
                win_reg[c] <= win_reg[c-1];
            end
        end
        if (state_reg == S_NEXT && ctl_reg.mask[j_reg])
        begin
            b_reg      <= 3'd7;
            prefix_reg <= '0;
            t_reg      <= target;
        end
        if (state_reg == S_CNT)
        begin
            cnt_reg <= cnt_c;
        end
        if (state_reg == S_SUM)
        begin
            if (total <= t_reg)
            begin
                prefix_reg[b_reg] <= 1'b1;
                t_reg             <= t_reg - total;
            end
            b_reg <= b_reg - 1'b1;
        end
        if (emit)
        begin
            med_reg  <= prefix_reg;
            last_reg <= last_c;
            fd_reg   <= ctl_reg.fd && (j_reg == ctl_reg.jmax);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                j_reg <= '0;
            end
            else if (edge_shift)
            begin
                j_reg <= j_reg + 1'b1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("emitted result not presented");
    a_j_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (j_reg <= ctl_reg.jmax))
        else $error("result index beyond run");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == S_NEXT))
        else $error("job popped outside idle");
`endif

endmodule

// ===== design/median_filter_2d_unit.sv =====
// top level of the streaming 2d median filter
// Pixels enter on pix_in (valid/ready) in raster order, one beat per pixel;
// op marks drain beats that flush the bottom border after the last row.
// Medians leave on pix_out, up to 1 + k/2 beats per input beat at row ends,
// with last_of_run on the final beat of each run and frame_done on the last
// pixel of the plane. kernel_size, image_width and image_height are written
// over the APB port at byte addresses 0, 4 and 8; a write to any of these
// three restarts the plane. The front takes one pixel per cycle while the
// queue is not full, into a line store of one word per column, and hands one
// gathered column per beat to a four-entry queue. The back shifts the column
// into the window and finds each median by a radix search from the top bit
// down: a setup state, then a count state and a sum state for each bit, then
// an emit state. It takes the next job from the queue only when idle, after
// the last median of the current job.
// A stalled receiver holds the output register; the queue then fills and
// pix_in.ready drops. Reset clears counters, queue and output valid; the line
// store and window are not cleared and hold no data until written.
module median_filter_2d_unit #(
    parameter int MAX_KERNEL = mf2d_pkg::MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = mf2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mf2d_pkg::MAX_HEIGHT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    mf2d_in_if.sink      pix_in,
    mf2d_out_if.source   pix_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int WW     = $clog2(MAX_WIDTH) + 1;
    localparam int HW     = $clog2(MAX_HEIGHT) + 1;
    localparam int KODD   = (MAX_KERNEL % 2 == 1) ? MAX_KERNEL : MAX_KERNEL - 1;
    localparam int DATA_W = $bits(mf2d_pkg::job_ctl_t) + 8 * MAX_KERNEL;

    logic [mf2d_pkg::KW-1:0]    kernel_reg;
    logic [mf2d_pkg::DIM_W-1:0] width_reg;
    logic [mf2d_pkg::DIM_W-1:0] height_reg;

    logic              wr_en;
    logic              restart;
    logic [4:0]        k_odd;
    logic [3:0]        k_eff;
    logic [WW-1:0]     w_eff;
    logic [HW-1:0]     h_eff;
    mf2d_pkg::reg_idx_t idx;

    logic              push;
    logic [DATA_W-1:0] push_data;
    logic              full;
    logic              pop;
    logic [DATA_W-1:0] job_data;
    logic              empty;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = mf2d_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        restart = 1'b0;
        prdata  = '0;
        unique case (idx)
            mf2d_pkg::REG_KERNEL:
            begin
                restart = wr_en;
                prdata  = 32'(kernel_reg);
            end
            mf2d_pkg::REG_WIDTH:
            begin
                restart = wr_en;
                prdata  = 32'(width_reg);
            end
            mf2d_pkg::REG_HEIGHT:
            begin
                restart = wr_en;
                prdata  = 32'(height_reg);
            end
            default:
            begin
                restart = 1'b0;
                prdata  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= mf2d_pkg::KERNEL_RST;
            width_reg  <= mf2d_pkg::WIDTH_RST;
            height_reg <= mf2d_pkg::HEIGHT_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                mf2d_pkg::REG_KERNEL: kernel_reg <= pwdata[mf2d_pkg::KW-1:0];
                mf2d_pkg::REG_WIDTH:  width_reg  <= pwdata[mf2d_pkg::DIM_W-1:0];
                mf2d_pkg::REG_HEIGHT: height_reg <= pwdata[mf2d_pkg::DIM_W-1:0];
                default:              kernel_reg <= kernel_reg;
            endcase
        end
    end

    always_comb
    begin
        k_odd = kernel_reg[0] ? {1'b0, kernel_reg} : {1'b0, kernel_reg} + 1'b1;
        k_eff = (k_odd > 5'(KODD)) ? 4'(KODD) : k_odd[3:0];
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0)
        begin
            h_eff = HW'(1);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HW'(height_reg);
        end
    end

    mf2d_front #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WW         (WW),
        .HW         (HW),
        .DATA_W     (DATA_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in),
        .radius    (k_eff[3:1]),
        .width     (w_eff),
        .height    (h_eff),
        .restart   (restart),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    mf2d_fifo #(
        .DATA_W (DATA_W),
        .DEPTH  (4)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_data),
        .full  (full),
        .pop   (pop),
        .rdata (job_data),
        .empty (empty)
    );

    mf2d_back #(
        .MAX_KERNEL (MAX_KERNEL),
        .DATA_W     (DATA_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .kernel   (k_eff),
        .job_data (job_data),
        .empty    (empty),
        .pop      (pop),
        .pix_out  (pix_out)
    );

endmodule

// ===== test/median_filter_2d_unit_test.sv =====
// self-checking testbench of the streaming 2d median filter
module median_filter_2d_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LS_ROWS = mf2d_pkg::MAX_KERNEL_DEF - 1
                             + (mf2d_pkg::MAX_KERNEL_DEF == 1 ? 1 : 0);
    localparam int WD_LIMIT = 20000;
    localparam int SETTLE = 300;

    typedef struct packed {
        logic [7:0] med;
        logic       last;
        logic       fd;
    } median_t;
    typedef median_t median_list_t[$];

    typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;
    typedef struct {
        row_kind_t          kind;
        mf2d_pkg::reg_idx_t idx;
        logic [31:0]        value;
        logic               op;
        logic [7:0]         pix;
        bit                 typed;
        logic [7:0]         med;
        logic               fd;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    mf2d_in_if pin();
    mf2d_out_if pout();

    median_filter_2d_unit u_top (
        .clk(clk), .rst_n(rst_n), .pix_in(pin), .pix_out(pout),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [7:0] line_mem[LS_ROWS*mf2d_pkg::MAX_WIDTH_DEF];
    logic [7:0] win[mf2d_pkg::MAX_KERNEL_DEF][mf2d_pkg::MAX_KERNEL_DEF];
    int col_cnt = 0, row_cnt = 0, row_ptr = 0;
    int kernel_reg = 3, width_reg = 640, height_reg = 480;

    median_t median_q[$];
    int errors = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int items_sent = 0;

    function automatic logic [7:0] window_median(int k);
        int hist[256];
        int acc;
        int target;
        for (int v = 0; v < 256; v++) hist[v] = 0;
        for (int c = 0; c < k; c++)
            for (int r = 0; r < k; r++)
                hist[win[c][r]]++;
        acc = 0;
        target = (k * k) / 2;
        for (int v = 0; v < 256; v++)
        begin
            acc += hist[v];
            if (acc > target) return v[7:0];
        end
        return 8'hff;
    endfunction

    function automatic void shift_window(logic [7:0] column[mf2d_pkg::MAX_KERNEL_DEF]);
        for (int i = mf2d_pkg::MAX_KERNEL_DEF - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = column;
    endfunction

    function automatic void filter_step(input logic op, input logic [7:0] pix,
                                        output median_list_t res);
        int k, r, w, h, c, v, d, slot, y, x, jmax;
        bit drain;
        logic [7:0] column[mf2d_pkg::MAX_KERNEL_DEF];
        logic [7:0] edge_col[mf2d_pkg::MAX_KERNEL_DEF];
        median_t m;
        res = {};
        k = kernel_reg & 15;
        if ((k & 1) == 0) k++;
        if (k > 9) k = 9;
        r = k / 2;
        w = width_reg & 12'hfff;
        if (w < 1) w = 1;
        if (w > mf2d_pkg::MAX_WIDTH_DEF) w = mf2d_pkg::MAX_WIDTH_DEF;
        h = height_reg & 12'hfff;
        if (h < 1) h = 1;
        if (h > mf2d_pkg::MAX_HEIGHT_DEF) h = mf2d_pkg::MAX_HEIGHT_DEF;
        if (col_cnt >= w || row_cnt > h - 1 + r)
        begin
            col_cnt = 0;
            row_cnt = 0;
            row_ptr = 0;
        end
        drain = row_cnt >= h;
        if (op == mf2d_pkg::OP_DRAIN && !drain) return;
        c = col_cnt;
        for (int i = 0; i < mf2d_pkg::MAX_KERNEL_DEF; i++) column[i] = '0;
        for (int i = 0; i <= 2 * r; i++)
        begin
            v = row_cnt - 2 * r + i;
            if (v < 0) v = 0;
            if (v > h - 1) v = h - 1;
            d = row_cnt - v;
            if (d == 0 && !drain) column[i] = pix;
            else
            begin
                slot = (row_ptr + LS_ROWS - (d % LS_ROWS)) % LS_ROWS;
                column[i] = line_mem[slot * mf2d_pkg::MAX_WIDTH_DEF + c];
            end
        end
        if (!drain) line_mem[(row_ptr % LS_ROWS) * mf2d_pkg::MAX_WIDTH_DEF + c] = pix;
        if (c == 0)
            for (int i = 0; i < mf2d_pkg::MAX_KERNEL_DEF; i++) win[i] = column;
        else
            shift_window(column);
        y = row_cnt - r;
        jmax = (c == w - 1) ? r : 0;
        for (int j = 0; j <= jmax; j++)
        begin
            x = c - r + j;
            if (j > 0)
            begin
                edge_col = win[0];
                shift_window(edge_col);
            end
            if (y >= 0 && y < h && x >= 0)
            begin
                m.med = window_median(k);
                m.last = 1'b0;
                m.fd = (y == h - 1 && x == w - 1);
                res = {res, m};
            end
        end
        if (c == w - 1)
        begin
            col_cnt = 0;
            row_cnt++;
            row_ptr = (row_ptr + 1) % LS_ROWS;
            if (row_cnt > h - 1 + r)
            begin
                col_cnt = 0;
                row_cnt = 0;
                row_ptr = 0;
            end
        end
        else
            col_cnt++;
        if (res.size() > 0) res[res.size()-1].last = 1'b1;
    endfunction

    task automatic wait_idle();
        pin.valid <= 1'b0;
        while (median_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(mf2d_pkg::reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            mf2d_pkg::REG_KERNEL: kernel_reg = value & 15;
            mf2d_pkg::REG_WIDTH:  width_reg = value & 12'hfff;
            default:              height_reg = value & 12'hfff;
        endcase
        col_cnt = 0;
        row_cnt = 0;
        row_ptr = 0;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_sizes(logic [31:0] k, logic [31:0] w, logic [31:0] h);
        wait_idle();
        apb_write(mf2d_pkg::REG_KERNEL, k);
        apb_write(mf2d_pkg::REG_WIDTH, w);
        apb_write(mf2d_pkg::REG_HEIGHT, h);
    endtask

    task automatic put_beat(logic op, logic [7:0] pix, bit typed,
                            logic [7:0] med, logic fd);
        int gap;
        median_list_t res;
        median_t m;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                pin.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        pin.valid <= 1'b1;
        pin.op <= op;
        pin.pixel <= pix;
        do @(posedge clk); while (!pin.ready);
        filter_step(op, pix, res);
        if (typed)
        begin
            m = '{med: med, last: 1'b1, fd: fd};
            median_q = {median_q, m};
        end
        else
            median_q = {median_q, res};
        items_sent++;
        @(negedge clk);
    endtask

    task automatic stream_plane(int w, int h, int k);
        int kk, rows;
        kk = k & 15;
        if ((kk & 1) == 0) kk++;
        if (kk > 9) kk = 9;
        if (w < 1) w = 1;
        if (w > mf2d_pkg::MAX_WIDTH_DEF) w = mf2d_pkg::MAX_WIDTH_DEF;
        if (h < 1) h = 1;
        if (h > mf2d_pkg::MAX_HEIGHT_DEF) h = mf2d_pkg::MAX_HEIGHT_DEF;
        rows = h + kk / 2;
        for (int i = 0; i < rows * w; i++)
        begin
            // noise: stray drain in real rows, stray pixel in drain rows
            if ($urandom_range(0, 11) == 0)
                put_beat((i >= h * w) ? mf2d_pkg::OP_PIXEL : mf2d_pkg::OP_DRAIN,
                         8'($urandom), 0, '0, 0);
            put_beat((i >= h * w) ? mf2d_pkg::OP_DRAIN : mf2d_pkg::OP_PIXEL,
                     8'($urandom), 0, '0, 0);
        end
    endtask

    // receiver stall pattern
    int stall_mode = 0;
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 120);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: pout.ready <= 1'b1;
            1: pout.ready <= ($urandom_range(0, 3) != 0);
            2: pout.ready <= ($urandom_range(0, 3) == 0);
            default: pout.ready <= (stall_left % 16) < 10;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && pout.valid && pout.ready)
        begin
            if (median_q.size() == 0)
            begin
                $display("%0t unexpected beat median=%0d last=%0b fd=%0b", $realtime,
                         pout.median_pixel, pout.last_of_run, pout.frame_done);
                errors++;
            end
            else
            begin
                median_t e;
                e = median_q.pop_front();
                if (pout.median_pixel !== e.med || pout.last_of_run !== e.last ||
                    pout.frame_done !== e.fd)
                begin
                    $display({"%0t mismatch expected med=%0d last=%0b fd=%0b",
                              " actual med=%0d last=%0b fd=%0b"},
                             $realtime, e.med, e.last, e.fd, pout.median_pixel,
                             pout.last_of_run, pout.frame_done);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pin.valid && pin.ready) || (pout.valid && pout.ready) || !rst_n || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("FAIL median_filter_2d_unit");
            $finish;
        end
    end

    stim_row_t directed[$];

    initial
    begin
        int k, w, h;
        pin.valid = 1'b0;
        pin.op = mf2d_pkg::OP_PIXEL;
        pin.pixel = '0;
        // kernel 0 becomes 1: median is the pixel itself
        directed = '{
            '{ROW_CFG, mf2d_pkg::REG_KERNEL, 32'h0, 0, 0, 0, 0, 0},
            '{ROW_CFG, mf2d_pkg::REG_WIDTH, 32'd4, 0, 0, 0, 0, 0},
            '{ROW_CFG, mf2d_pkg::REG_HEIGHT, 32'hffff_f002, 0, 0, 0, 0, 0},
            '{ROW_BEAT, mf2d_pkg::REG_KERNEL, 0, mf2d_pkg::OP_PIXEL, 8'd0, 1, 8'd0, 0},
            '{ROW_BEAT, mf2d_pkg::REG_KERNEL, 0, mf2d_pkg::OP_PIXEL, 8'd255, 1, 8'd255, 0},
            '{ROW_BEAT, mf2d_pkg::REG_KERNEL, 0, mf2d_pkg::OP_DRAIN, 8'd77, 0, 0, 0},
            '{ROW_BEAT, mf2d_pkg::REG_KERNEL, 0, mf2d_pkg::OP_PIXEL, 8'h55, 1, 8'h55, 0},
            '{ROW_BEAT, mf2d_pkg::REG_KERNEL, 0, mf2d_pkg::OP_PIXEL, 8'haa, 1, 8'haa, 0},
            '{ROW_BEAT, mf2d_pkg::REG_KERNEL, 0, mf2d_pkg::OP_PIXEL, 8'd1, 1, 8'd1, 0},
            '{ROW_BEAT, mf2d_pkg::REG_KERNEL, 0, mf2d_pkg::OP_PIXEL, 8'd128, 1, 8'd128, 0},
            '{ROW_BEAT, mf2d_pkg::REG_KERNEL, 0, mf2d_pkg::OP_PIXEL, 8'd254, 1, 8'd254, 0},
            '{ROW_BEAT, mf2d_pkg::REG_KERNEL, 0, mf2d_pkg::OP_PIXEL, 8'd7, 1, 8'd7, 1},
            // kernel 2 becomes 3, 3x2 plane, pixel during drain rows
            '{ROW_CFG, mf2d_pkg::REG_KERNEL, 32'd2, 0, 0, 0, 0, 0},
            '{ROW_CFG, mf2d_pkg::REG_WIDTH, 32'd3, 0, 0, 0, 0, 0},
            '{ROW_CFG, mf2d_pkg::REG_HEIGHT, 32'd2, 0, 0, 0, 0, 0},
            '{ROW_BEAT, mf2d_pkg::REG_KERNEL, 0, mf2d_pkg::OP_PIXEL, 8'd255, 0, 0, 0},
            '{ROW_BEAT, mf2d_pkg::REG_KERNEL, 0, mf2d_pkg::OP_PIXEL, 8'd0, 0, 0, 0},
            '{ROW_BEAT, mf2d_pkg::REG_KERNEL, 0, mf2d_pkg::OP_PIXEL, 8'd200, 0, 0, 0},
            '{ROW_BEAT, mf2d_pkg::REG_KERNEL, 0, mf2d_pkg::OP_PIXEL, 8'd10, 0, 0, 0},
            '{ROW_BEAT, mf2d_pkg::REG_KERNEL, 0, mf2d_pkg::OP_PIXEL, 8'd255, 0, 0, 0},
            '{ROW_BEAT, mf2d_pkg::REG_KERNEL, 0, mf2d_pkg::OP_PIXEL, 8'd90, 0, 0, 0},
            '{ROW_BEAT, mf2d_pkg::REG_KERNEL, 0, mf2d_pkg::OP_DRAIN, 8'd0, 0, 0, 0},
            '{ROW_BEAT, mf2d_pkg::REG_KERNEL, 0, mf2d_pkg::OP_PIXEL, 8'd33, 0, 0, 0},
            '{ROW_BEAT, mf2d_pkg::REG_KERNEL, 0, mf2d_pkg::OP_DRAIN, 8'd0, 0, 0, 0}
        };
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
            begin
                wait_idle();
                apb_write(directed[i].idx, directed[i].value);
            end
            else
                put_beat(directed[i].op, directed[i].pix, directed[i].typed,
                         directed[i].med, directed[i].fd);
        end

        // extremes: oversized plane, largest kernel on tiny planes
        set_sizes(32'd1, 32'd4095, 32'd4095);
        for (int i = 0; i < 16; i++)
            put_beat(mf2d_pkg::OP_PIXEL, 8'($urandom), 0, '0, 0);
        set_sizes(32'd15, 32'd1, 32'd1);
        stream_plane(1, 1, 15);
        set_sizes(32'd9, 32'd5, 32'd3);
        stream_plane(5, 3, 9);

        while (items_sent < 260)
        begin
            k = $urandom_range(0, 15);
            w = $urandom_range(0, 9);
            h = $urandom_range(0, 6);
            set_sizes(k, w, h);
            repeat ($urandom_range(1, 2)) stream_plane(w, h, k);
        end

        wait_idle();
        if (errors == 0 && median_q.size() == 0)
            $display("PASS median_filter_2d_unit");
        else
            $display("FAIL median_filter_2d_unit");
        $finish;
    end
endmodule

// ===== files.f =====
design/mf2d_pkg.sv
design/mf2d_if.sv
design/mf2d_fifo.sv
design/mf2d_front.sv
design/mf2d_back.sv
design/median_filter_2d_unit.sv
test/median_filter_2d_unit_test.sv
